// ===== rtl/core/maa_pkg.sv =====
// Types and constants shared by the multichannel ADC averager modules.
package maa_pkg;

  localparam int SAMPLE_W = 12;
  localparam int ACC_W    = 16;
  localparam int CNT_W    = 5;
  localparam int CH_W     = 4;
  localparam int LOG2_W   = 3;

  localparam logic                REQ_SAMPLE   = 1'b0;
  localparam logic                REQ_READ     = 1'b1;
  localparam logic [LOG2_W-1:0]   LOG2_MAX     = 3'd4;
  localparam logic [LOG2_W-1:0]   LOG2_RESET   = 3'd3;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 12'hFFF;

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep_step;
    logic emit_done;
  } maa_cmd_t;

  typedef struct packed {
    logic sweep_start;
    logic sweep_last;
    logic out_busy;
  } maa_sts_t;

endpackage

// ===== rtl/core/maa_ctrl.sv =====
// Controller state machine for the multichannel ADC averager.
module maa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  maa_pkg::maa_sts_t sts,
  output maa_pkg::maa_cmd_t cmd
);
  import maa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = sts.sweep_start ? S_SWEEP : S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/maa_datapath.sv =====
// Datapath of the multichannel ADC averager: stores, accumulators and result word.
module maa_datapath #(
  parameter int CHANNELS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  maa_pkg::maa_cmd_t                 cmd,
  output maa_pkg::maa_sts_t                 sts,
  input  logic                              in_req,
  input  logic [maa_pkg::CH_W-1:0]          in_channel,
  input  logic [maa_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic                              in_last,
  input  logic                              cfg_valid,
  input  logic [maa_pkg::LOG2_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [maa_pkg::SAMPLE_W-1:0]      out_data,
  output logic                              out_restart,
  output logic                              out_avg_ready
);
  import maa_pkg::*;

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [SAMPLE_W-1:0] raw_mem [CHANNELS];
  logic [ACC_W-1:0]    acc_mem [CHANNELS];
  logic [SAMPLE_W-1:0] avg_mem [CHANNELS];

  logic                req_q;
  logic [CH_W-1:0]     ch_q;
  logic [SAMPLE_W-1:0] smp_q;
  logic                last_q;
  logic [LOG2_W-1:0]   avg_log2;
  logic [CNT_W-1:0]    scan_count;
  logic [ADDR_W-1:0]   sweep_idx;

  logic [LOG2_W-1:0]   shift;
  logic [5:0]          ch_ext;
  logic                ch_ok;
  logic [ADDR_W-1:0]   ch_idx;
  logic [ADDR_W-1:0]   addr;
  logic [ACC_W-1:0]    acc_rd;
  logic [ACC_W-1:0]    acc_shr;
  logic [SAMPLE_W-1:0] avg_sat;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    thresh;
  logic                scan_end;
  logic [SAMPLE_W-1:0] read_val;

  assign shift    = (avg_log2 > LOG2_MAX) ? LOG2_MAX : avg_log2;
  assign ch_ext   = {2'b00, ch_q};
  assign ch_ok    = ch_ext < 6'(CHANNELS);
  assign ch_idx   = ch_ext[ADDR_W-1:0];
  assign addr     = cmd.sweep_step ? sweep_idx : ch_idx;
  assign acc_rd   = acc_mem[addr];
  assign acc_shr  = acc_rd >> shift;
  assign avg_sat  = (acc_shr > ACC_W'(SAMPLE_MAX)) ? SAMPLE_MAX : acc_shr[SAMPLE_W-1:0];
  assign cnt_inc  = scan_count + CNT_W'(1);
  assign thresh   = CNT_W'(1) << shift;
  assign scan_end = (req_q == REQ_SAMPLE) && last_q && (shift != '0);
  assign read_val = !ch_ok ? '0 : ((shift == '0) ? raw_mem[ch_idx] : avg_mem[ch_idx]);

  assign sts.sweep_start = scan_end && (cnt_inc >= thresh);
  assign sts.sweep_last  = sweep_idx == ADDR_W'(CHANNELS - 1);
  assign sts.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= in_req;
      ch_q   <= in_channel;
      smp_q  <= in_sample;
      last_q <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_log2   <= LOG2_RESET;
      scan_count <= '0;
      sweep_idx  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        raw_mem[i] <= '0;
        acc_mem[i] <= '0;
        avg_mem[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        avg_log2 <= cfg_data;
      end
      if (cmd.exec && req_q == REQ_SAMPLE) begin
        if (ch_ok) begin
          raw_mem[ch_idx] <= smp_q;
          if (shift != '0) begin
            acc_mem[ch_idx] <= acc_rd + ACC_W'(smp_q);
          end
        end
        if (scan_end) begin
          scan_count <= sts.sweep_start ? '0 : cnt_inc;
        end
      end
      if (cmd.sweep_step) begin
        avg_mem[sweep_idx] <= avg_sat;
        acc_mem[sweep_idx] <= '0;
        sweep_idx          <= sts.sweep_last ? '0 : sweep_idx + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.exec && !sts.sweep_start) || cmd.emit_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !sts.sweep_start) begin
      out_data      <= (req_q == REQ_READ) ? read_val : '0;
      out_restart   <= scan_end;
      out_avg_ready <= 1'b0;
    end else if (cmd.emit_done) begin
      out_data      <= '0;
      out_restart   <= 1'b0;
      out_avg_ready <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/multichannel_adc_averager.sv =====
// Top level of the multichannel ADC averager: stream ports, controller and datapath.
// An accepted word is registered on entry to S_EXEC, which registers its result word once the
// output is not stalled; a new word is taken only after that. A scan end that completes a block
// adds a sweep through S_SWEEP, one step per channel accumulator, then S_DONE emits a flag word.
// Reset: rst is synchronous, active high; clears all stores, scan count and
// sets avg_log2 to 3.
module multichannel_adc_averager #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // channel[3:0], sample[15:4]
  input  logic [0:0]  s_tuser,   // req_type[0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // read_data[11:0], zero[15:12]
  output logic [1:0]  m_tuser,   // restart_scan[0], average_ready[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);
  import maa_pkg::*;

  maa_cmd_t            cmd;
  maa_sts_t            sts;
  logic [SAMPLE_W-1:0] read_data;
  logic                restart_scan;
  logic                average_ready;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'b0000, read_data};
  assign m_tuser   = {average_ready, restart_scan};

  maa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  maa_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_req        (s_tuser[0]),
    .in_channel    (s_tdata[3:0]),
    .in_sample     (s_tdata[15:4]),
    .in_last       (s_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_data      (read_data),
    .out_restart   (restart_scan),
    .out_avg_ready (average_ready)
  );

endmodule

// ===== rtl/core/maa_checker.sv =====
// Port checker for the multichannel ADC averager and its bind.
module maa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [0:0]  s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_data
);

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("restart and average flags both set");

  a_flag_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[0] || m_tuser[1])) |-> (m_tdata == 16'h0000))
    else $error("flagged result carries data");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a word is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result word changed");

endmodule

bind multichannel_adc_averager maa_checker u_maa_checker (.*);
